[rtl/assert_macros.svh]
// Assertion macros for the RTL of the UART receive block.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a next-cycle implication outside reset
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

[rtl/hduart_pkg.sv]
// Shared constants for the half-duplex 8N1 UART with receive FIFO.
// No dependencies.
package hduart_pkg;

    // FIFO depth default
    localparam int FIFO_DEPTH_DEF = 16;

    // Register reset values and widths
    localparam int          TICK_W        = 8;
    localparam int          BITCNT_W      = 5;
    localparam int          STOP_W        = 4;
    localparam logic [7:0]  START_LEN_RST = 8'd78;
    localparam logic [7:0]  BIT_LEN_RST   = 8'd52;
    localparam logic [3:0]  STOP_IDX_RST  = 4'd9;

    // Register indexes
    localparam logic [1:0]  REG_START_LEN = 2'd0;
    localparam logic [1:0]  REG_BIT_LEN   = 2'd1;
    localparam logic [1:0]  REG_STOP_IDX  = 2'd2;

    // Bits per data word and the all-ones bit counter before the first bit
    localparam logic [4:0]  DATA_BITS     = 5'd8;
    localparam logic [4:0]  BITCNT_RST    = 5'h1F;

    // Input beat width
    localparam int          IN_W          = 16;

endpackage

[rtl/half_duplex_uart_8n1_rx_fifo.sv]
// Half-duplex 8N1 UART with a receive ring FIFO, one clock tick per input beat.
// Depends on hduart_pkg and assert_macros.svh.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tick: rx_line, tx_start, tx_byte, read_strobe
//  m_*       out  tvalid/tready      result: line levels, status, popped byte, level
//  p*        in   APB write/read     start_length, bit_length, stop_index
//
// A new tick is taken each cycle while the result register is empty or being
// drained. The FIFO read port is registered and read in the accepting cycle.
// Reset is synchronous, active low, and clears control state; FIFO contents are
// not cleared. A stalled result holds s_tready low.
`include "assert_macros.svh"

module half_duplex_uart_8n1_rx_fifo
    import hduart_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1),
    localparam int OUT_BITS  = 13 + CNT_W,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [10] read_strobe, rest zero
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [0] tx_line, [1] rx_active, [2] tx_active, [3] read_valid, [11:4] read_byte,
    // [12 +: CNT_W] fifo_level, [12+CNT_W] overflow, rest zero
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Configuration registers
    logic [TICK_W-1:0] start_len_reg;
    logic [TICK_W-1:0] bit_len_reg;
    logic [STOP_W-1:0] stop_idx_reg;

    // Engine state
    logic [1:0]          mode_reg,     mode_next;
    logic [7:0]          shifter_reg,  shifter_next;
    logic [BITCNT_W-1:0] bit_cnt_reg,  bit_cnt_next;
    logic [TICK_W-1:0]   tick_cnt_reg, tick_cnt_next;
    logic [TICK_W-1:0]   tick_lim_reg, tick_lim_next;
    logic                line_reg,     line_next;

    // FIFO state
    logic [7:0]       fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic             ovf_reg,    ovf_next;
    logic             rd_valid_reg;
    logic [7:0]       rd_data_reg;
    logic             m_valid_reg;

    // Beat fields and handshakes
    logic             s_accept;
    logic             rx_line, tx_start, read_strobe;
    logic [7:0]       tx_byte;
    logic             pop, push;
    logic [CNT_W-1:0] fill_after_pop;
    logic [PTR_W-1:0] rd_ptr_after_pop;
    logic [TICK_W-1:0] tick_inc;
    logic              cfg_wr;

    assign rx_line     = s_tdata[0];
    assign tx_start    = s_tdata[1];
    assign tx_byte     = s_tdata[9:2];
    assign read_strobe = s_tdata[10];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_len_reg <= START_LEN_RST;
            bit_len_reg   <= BIT_LEN_RST;
            stop_idx_reg  <= STOP_IDX_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_START_LEN: start_len_reg <= pwdata[TICK_W-1:0];
                REG_BIT_LEN:   bit_len_reg   <= pwdata[TICK_W-1:0];
                REG_STOP_IDX:  stop_idx_reg  <= pwdata[STOP_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_START_LEN: prdata = {{(32-TICK_W){1'b0}}, start_len_reg};
            REG_BIT_LEN:   prdata = {{(32-TICK_W){1'b0}}, bit_len_reg};
            REG_STOP_IDX:  prdata = {{(32-STOP_W){1'b0}}, stop_idx_reg};
            default:       prdata = '0;
        endcase
    end

    // FIFO pop comes before any push in the same tick
    assign pop              = read_strobe && (fill_reg != '0);
    assign fill_after_pop   = pop ? fill_reg - CNT_W'(1) : fill_reg;
    assign rd_ptr_after_pop = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign tick_inc         = tick_cnt_reg + TICK_W'(1);

    // Next state for one tick: transmit request, else receive start, else timer
    always_comb begin
        mode_next     = mode_reg;
        shifter_next  = shifter_reg;
        bit_cnt_next  = bit_cnt_reg;
        tick_cnt_next = tick_cnt_reg;
        tick_lim_next = tick_lim_reg;
        line_next     = line_reg;
        push          = 1'b0;
        if (tx_start && mode_reg != MODE_TX) begin
            mode_next     = MODE_TX;
            line_next     = 1'b0;
            shifter_next  = tx_byte;
            bit_cnt_next  = BITCNT_RST;
            tick_cnt_next = '0;
            tick_lim_next = bit_len_reg;
        end else if (mode_reg == MODE_IDLE) begin
            if (!rx_line) begin
                mode_next     = MODE_RX;
                shifter_next  = '0;
                bit_cnt_next  = BITCNT_RST;
                tick_cnt_next = '0;
                tick_lim_next = start_len_reg;
            end
        end else if (tick_inc != tick_lim_reg) begin
            tick_cnt_next = tick_inc;
        end else begin
            // Bit event: restart the timer and advance the bit counter
            tick_cnt_next = '0;
            tick_lim_next = bit_len_reg;
            bit_cnt_next  = bit_cnt_reg + BITCNT_W'(1);
            if (mode_reg == MODE_TX) begin
                if (bit_cnt_next < DATA_BITS) begin
                    line_next    = shifter_reg[0];
                    shifter_next = {1'b0, shifter_reg[7:1]};
                end else begin
                    line_next = 1'b1;
                    if (bit_cnt_next >= {1'b0, stop_idx_reg})
                        mode_next = MODE_IDLE;
                end
            end else if (bit_cnt_next < DATA_BITS) begin
                shifter_next = shifter_reg | (8'(rx_line) << bit_cnt_next[2:0]);
            end else begin
                mode_next = MODE_IDLE;
                push      = rx_line;
            end
        end
    end

    // FIFO pointers and level; a full push drops the oldest byte
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_after_pop;
        fill_next   = fill_after_pop;
        ovf_next    = ovf_reg;
        if (push) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (fill_after_pop >= CNT_FULL) begin
                ovf_next    = 1'b1;
                rd_ptr_next = ptr_inc(rd_ptr_after_pop);
            end else begin
                fill_next = fill_after_pop + CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            shifter_reg  <= '0;
            bit_cnt_reg  <= BITCNT_RST;
            tick_cnt_reg <= '0;
            tick_lim_reg <= '0;
            line_reg     <= 1'b1;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg     <= mode_next;
                shifter_reg  <= shifter_next;
                bit_cnt_reg  <= bit_cnt_next;
                tick_cnt_reg <= tick_cnt_next;
                tick_lim_reg <= tick_lim_next;
                line_reg     <= line_next;
                wr_ptr_reg   <= wr_ptr_next;
                rd_ptr_reg   <= rd_ptr_next;
                fill_reg     <= fill_next;
                ovf_reg      <= ovf_next;
                rd_valid_reg <= pop;
            end
            // Hold the result beat until it is taken
            if (s_accept)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // FIFO storage with registered read
    always_ff @(posedge aclk) begin
        if (s_accept && push)
            fifo_mem[wr_ptr_reg] <= shifter_reg;
        if (s_accept && pop)
            rd_data_reg <= fifo_mem[rd_ptr_reg];
    end

    // Result beat straight from the state registers
    always_comb begin
        m_tdata                = '0;
        m_tdata[0]             = line_reg;
        m_tdata[1]             = (mode_reg == MODE_RX);
        m_tdata[2]             = (mode_reg == MODE_TX);
        m_tdata[3]             = rd_valid_reg;
        m_tdata[11:4]          = rd_valid_reg ? rd_data_reg : 8'h00;
        m_tdata[12 +: CNT_W]   = fill_reg;
        m_tdata[12 + CNT_W]    = ovf_reg;
    end
    assign m_tvalid = m_valid_reg;

    // Checks
    `ASSERT_CLKD(a_fill_max, aclk, aresetn, fill_reg <= CNT_FULL, "fill level above depth")
    `ASSERT_NEXT(a_ovf_sticky, aclk, aresetn, ovf_reg, ovf_reg, "overflow flag cleared")
    `ASSERT_NEXT(a_tx_start, aclk, aresetn, s_accept && tx_start && mode_reg != MODE_TX,
        mode_reg == MODE_TX && !line_reg, "transmit request did not start a frame")
    `ASSERT_NEXT(a_pop_valid, aclk, aresetn, s_accept && read_strobe && fill_reg != '0,
        rd_valid_reg && fill_reg == $past(fill_reg) - CNT_W'(1) + CNT_W'($past(push)),
        "pop did not update level")

endmodule

[verif/uart_link_checker.sv]
`timescale 1ns / 1ps
// Passive checker for the half-duplex 8N1 UART with receive FIFO: predicts each result beat
// from the tick beats and register writes it observes, then compares field by field.
// Depends on hduart_pkg.
module uart_link_checker
    import hduart_pkg::*;
#(
    parameter int LEVEL_W = 5,
    parameter int OUT_W   = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [10] read_strobe, rest zero
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // [0] tx_line, [1] rx_active, [2] tx_active, [3] read_valid, [11:4] read_byte,
    // [12 +: LEVEL_W] fifo_level, [12+LEVEL_W] overflow, rest zero
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output int               fail_count,
    output int               pending_beats,
    output int               bytes_stored,
    output logic             link_busy
);

    typedef enum logic [1:0] {LINK_IDLE, LINK_RX, LINK_TX} link_mode_t;

    typedef struct packed {
        logic               tx_line;
        logic               rx_active;
        logic               tx_active;
        logic               read_valid;
        logic [7:0]         read_byte;
        logic [LEVEL_W-1:0] level;
        logic               overflow;
    } uart_result_t;

    // Register copies
    logic [7:0]         start_len_cfg;
    logic [7:0]         bit_len_cfg;
    logic [3:0]         stop_cfg;

    // Line state
    link_mode_t         mode;
    logic [7:0]         shifter;
    logic [4:0]         bit_idx;
    logic [7:0]         ticks;
    logic [7:0]         limit;
    logic               line_lvl;

    // Receive ring
    logic [7:0]         rx_store [FIFO_DEPTH_DEF];
    int                 wr_ptr;
    int                 rd_ptr;
    logic [LEVEL_W-1:0] fill_cnt;
    logic               ovf_flag;

    uart_result_t       awaited_results [$];
    uart_result_t       oldest;
    uart_result_t       fresh;

    function automatic int ring_next(input int p);
        return (p == FIFO_DEPTH_DEF - 1) ? 0 : p + 1;
    endfunction

    // Advance the line by one tick and build the result it produces
    task automatic advance_link(input logic rx, input logic start_tx, input logic [7:0] tx_data,
                                input logic rd, output uart_result_t res);
        logic       popped;
        logic [7:0] popped_byte;
        popped      = 1'b0;
        popped_byte = 8'h00;

        // Pop comes before any push in the same tick
        if (rd && fill_cnt != 0) begin
            popped_byte = rx_store[rd_ptr];
            rd_ptr      = ring_next(rd_ptr);
            fill_cnt    = fill_cnt - 1'b1;
            popped      = 1'b1;
        end

        if (start_tx && mode != LINK_TX) begin
            mode     = LINK_TX;
            line_lvl = 1'b0;
            shifter  = tx_data;
            bit_idx  = BITCNT_RST;
            ticks    = 8'd0;
            limit    = bit_len_cfg;
        end else if (mode == LINK_IDLE) begin
            if (!rx) begin
                mode    = LINK_RX;
                shifter = 8'd0;
                bit_idx = BITCNT_RST;
                ticks   = 8'd0;
                limit   = start_len_cfg;
            end
        end else begin
            ticks = ticks + 8'd1;
            if (ticks == limit) begin
                ticks   = 8'd0;
                limit   = bit_len_cfg;
                bit_idx = bit_idx + 5'd1;
                if (mode == LINK_TX) begin
                    if (bit_idx < DATA_BITS) begin
                        line_lvl = shifter[0];
                        shifter  = shifter >> 1;
                    end else begin
                        line_lvl = 1'b1;
                        if (bit_idx >= {1'b0, stop_cfg})
                            mode = LINK_IDLE;
                    end
                end else if (bit_idx < DATA_BITS) begin
                    shifter = shifter | (8'(rx) << bit_idx[2:0]);
                end else begin
                    // Stop sample: keep the byte only on a high line
                    mode = LINK_IDLE;
                    if (rx) begin
                        rx_store[wr_ptr] = shifter;
                        wr_ptr           = ring_next(wr_ptr);
                        bytes_stored++;
                        if (fill_cnt >= FIFO_DEPTH_DEF) begin
                            ovf_flag = 1'b1;
                            rd_ptr   = ring_next(rd_ptr);
                        end else begin
                            fill_cnt = fill_cnt + 1'b1;
                        end
                    end
                end
            end
        end

        res.tx_line    = line_lvl;
        res.rx_active  = (mode == LINK_RX);
        res.tx_active  = (mode == LINK_TX);
        res.read_valid = popped;
        res.read_byte  = popped_byte;
        res.level      = fill_cnt;
        res.overflow   = ovf_flag;
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count    = 0;
            bytes_stored  = 0;
            awaited_results.delete();
            start_len_cfg = START_LEN_RST;
            bit_len_cfg   = BIT_LEN_RST;
            stop_cfg      = STOP_IDX_RST;
            mode          = LINK_IDLE;
            shifter       = 8'd0;
            bit_idx       = BITCNT_RST;
            ticks         = 8'd0;
            limit         = 8'd0;
            line_lvl      = 1'b1;
            wr_ptr        = 0;
            rd_ptr        = 0;
            fill_cnt      = '0;
            ovf_flag      = 1'b0;
        end else begin
            // Compare the result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $error("result beat 0x%0h arrived with no tick awaiting it", m_tdata);
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("tx_line", oldest.tx_line, m_tdata[0]);
                    check_field("rx_active", oldest.rx_active, m_tdata[1]);
                    check_field("tx_active", oldest.tx_active, m_tdata[2]);
                    check_field("read_valid", oldest.read_valid, m_tdata[3]);
                    check_field("read_byte", oldest.read_byte, m_tdata[11:4]);
                    check_field("fifo_level", oldest.level, m_tdata[12 +: LEVEL_W]);
                    check_field("overflow", oldest.overflow, m_tdata[12 + LEVEL_W]);
                    check_field("padding", 0, m_tdata[OUT_W-1:13+LEVEL_W]);
                end
            end

            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_START_LEN: start_len_cfg = pwdata[7:0];
                    REG_BIT_LEN:   bit_len_cfg   = pwdata[7:0];
                    REG_STOP_IDX:  stop_cfg      = pwdata[3:0];
                    default: ;
                endcase
            end

            // Predict the result of each accepted tick
            if (s_tvalid && s_tready) begin
                advance_link(s_tdata[0], s_tdata[1], s_tdata[9:2], s_tdata[10], fresh);
                awaited_results.push_back(fresh);
            end
        end
        pending_beats = awaited_results.size();
        link_busy     = (mode != LINK_IDLE);
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the UART receive-FIFO testbench: clock, reset, tick stimulus, register writes, result back-pressure,
// watchdog and verdict. Depends on hduart_pkg, half_duplex_uart_8n1_rx_fifo and uart_link_checker.
module testbench;
    import hduart_pkg::*;

    localparam int LEVEL_W       = $clog2(FIFO_DEPTH_DEF + 1);
    localparam int OUT_W         = ((13 + LEVEL_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES   = 48;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_BATCH  = 32;
    localparam int SETTLE_ROUNDS = 200;
    localparam int PHASES        = 7;

    typedef enum {FLOW_OPEN, FLOW_SENDER, FLOW_RECEIVER, FLOW_BOTH} flow_t;

    typedef struct {
        int    start_len;
        int    bit_len;
        int    stop_idx;
        int    read_pct;
        int    ticks;
        flow_t flow;
        bit    hold;
    } phase_t;

    logic             aclk;
    logic             aresetn;
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [10] read_strobe, rest zero
    logic [IN_W-1:0]  s_tdata;
    logic             s_tvalid;
    logic             s_tready;
    // [0] tx_line, [1] rx_active, [2] tx_active, [3] read_valid, [11:4] read_byte,
    // [12 +: LEVEL_W] fifo_level, [12+LEVEL_W] overflow, rest zero
    logic [OUT_W-1:0] m_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [3:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int               fail_count;
    int               pending_beats;
    int               bytes_stored;
    logic             link_busy;

    int               start_len;
    int               bit_len;
    int               stop_idx;
    int               read_pct;
    int               gap_pct;
    int               stall_pct;
    int               ticks_driven;
    int               settings_used;
    int               quiet_cycles = 0;
    bit               hold_off_req;
    phase_t           plan [PHASES];

    half_duplex_uart_8n1_rx_fifo DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    uart_link_checker #(
        .LEVEL_W (LEVEL_W),
        .OUT_W   (OUT_W)
    ) link_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .bytes_stored  (bytes_stored),
        .link_busy     (link_busy)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [IN_W-1:0] pack_tick(input logic rx, input logic start_tx,
                                                  input logic [7:0] tx_data, input logic rd);
        logic [IN_W-1:0] beat;
        beat      = '0;
        beat[0]   = rx;
        beat[1]   = start_tx;
        beat[9:2] = tx_data;
        beat[10]  = rd;
        return beat;
    endfunction

    function automatic logic rd_roll();
        return ($urandom_range(99) < read_pct);
    endfunction

    // Offer one tick beat, with a random gap ahead of it, and wait for acceptance
    task automatic drive_tick(input logic [IN_W-1:0] beat);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        ticks_driven++;
    endtask

    // Stop offering, then feed idle ticks until every result is in and the line is idle, or the round limit runs out
    task automatic settle_link();
        int rounds;
        rounds = 0;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        wait (pending_beats == 0);
        @(negedge aclk);
        while (link_busy && rounds < SETTLE_ROUNDS) begin
            repeat (SETTLE_BATCH) drive_tick(pack_tick(1'b1, 1'b0, 8'($urandom), rd_roll()));
            s_tvalid <= 1'b0;
            @(negedge aclk);
            wait (pending_beats == 0);
            @(negedge aclk);
            rounds++;
        end
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Serial frame timed to the current settings; occasional glitch, bad stop or cancel
    task automatic send_frame();
        logic [7:0] data;
        logic       stop_level;
        logic       level;
        int         span;
        int         glitch_at;
        int         cancel_at;
        int         k;
        int         j;
        data       = 8'($urandom);
        stop_level = ($urandom_range(9) != 0);
        span       = start_len + 8 * bit_len;
        glitch_at  = ($urandom_range(9) == 0) ? $urandom_range(1, span) : -1;
        cancel_at  = ($urandom_range(19) == 0) ? $urandom_range(1, span) : -1;
        drive_tick(pack_tick(1'b0, 1'b0, 8'($urandom), rd_roll()));
        for (k = 1; k <= span; k++) begin
            j     = (k <= start_len) ? 0 : (k - start_len + bit_len - 1) / bit_len;
            level = (j >= 8) ? stop_level : data[j];
            if (k == glitch_at)
                level = ~level;
            drive_tick(pack_tick(level, k == cancel_at, 8'($urandom), rd_roll()));
        end
        repeat ($urandom_range(0, 3))
            drive_tick(pack_tick(1'b1, 1'b0, 8'($urandom), rd_roll()));
    endtask

    // Transmit request, then ticks covering the frame with line noise and at times a repeat request
    task automatic send_transmit();
        int span;
        int again_at;
        int k;
        span     = (stop_idx + 1) * bit_len + $urandom_range(0, 2);
        again_at = ($urandom_range(2) == 0) ? $urandom_range(1, span) : -1;
        drive_tick(pack_tick(1'b1, 1'b1, 8'($urandom), rd_roll()));
        for (k = 1; k <= span; k++)
            drive_tick(pack_tick($urandom_range(4) != 0, k == again_at, 8'($urandom),
                                 rd_roll()));
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $error("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p;
        int phase_mark;
        int pick;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_off_req  = 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        read_pct      = 30;
        start_len     = START_LEN_RST;
        bit_len       = BIT_LEN_RST;
        stop_idx      = STOP_IDX_RST;
        ticks_driven  = 0;
        settings_used = 1;

        // start, bit, stop, read %, ticks, flow, long hold-off
        plan[0] = '{3,   2,   9,  30, 50,  FLOW_OPEN,     1'b0};
        plan[1] = '{60,  1,   15, 40, 60,  FLOW_RECEIVER, 1'b0};
        plan[2] = '{6,   4,   12, 50, 50,  FLOW_BOTH,     1'b0};
        plan[3] = '{2,   3,   10, 20, 60,  FLOW_OPEN,     1'b1};
        plan[4] = '{1,   12,  8,  10, 40,  FLOW_SENDER,   1'b0};
        plan[5] = '{1,   1,   8,  0,  320, FLOW_SENDER,   1'b0};
        plan[6] = '{5,   1,   11, 60, 40,  FLOW_RECEIVER, 1'b0};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed ticks at the reset settings: empty read, receive start,
        // cancel by transmit, transmit while busy, receive start during transmit
        drive_tick(pack_tick(1'b1, 1'b0, 8'h00, 1'b0));
        drive_tick(pack_tick(1'b1, 1'b0, 8'hFF, 1'b1));
        drive_tick(pack_tick(1'b0, 1'b0, 8'h00, 1'b0));
        drive_tick(pack_tick(1'b0, 1'b0, 8'h5A, 1'b1));
        drive_tick(pack_tick(1'b1, 1'b1, 8'h00, 1'b0));
        drive_tick(pack_tick(1'b1, 1'b1, 8'hFF, 1'b0));
        drive_tick(pack_tick(1'b0, 1'b0, 8'hFF, 1'b1));
        drive_tick(pack_tick(1'b1, 1'b0, 8'hA5, 1'b1));

        // Random phases, each under its own register setting and flow pattern
        for (p = 0; p < PHASES; p++) begin
            settle_link();
            apb_write({REG_START_LEN, 2'b00}, plan[p].start_len);
            apb_write({REG_BIT_LEN, 2'b00}, plan[p].bit_len);
            apb_write({REG_STOP_IDX, 2'b00}, plan[p].stop_idx);
            start_len = plan[p].start_len;
            bit_len   = plan[p].bit_len;
            stop_idx  = plan[p].stop_idx;
            read_pct  = plan[p].read_pct;
            case (plan[p].flow)
                FLOW_SENDER: begin
                    gap_pct   = 62;
                    stall_pct = 0;
                end
                FLOW_RECEIVER: begin
                    gap_pct   = 0;
                    stall_pct = 62;
                end
                FLOW_BOTH: begin
                    gap_pct   = 30;
                    stall_pct = 30;
                end
                default: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            settings_used++;
            if (plan[p].hold)
                hold_off_req = 1'b1;
            phase_mark = ticks_driven;
            while (ticks_driven - phase_mark < plan[p].ticks) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame();
                else if (pick < 85)
                    send_transmit();
                else
                    repeat ($urandom_range(1, 8))
                        drive_tick(pack_tick(1'($urandom), $urandom_range(9) == 0,
                                             8'($urandom), rd_roll()));
            end
        end

        settle_link();
        repeat (8) @(negedge aclk);

        $display("Drove %0d ticks under %0d register settings: frames, bad stops, glitches,",
                 ticks_driven, settings_used);
        $display("transmits, cancels and FIFO overflow; %0d bytes were stored.", bytes_stored);
        if (pending_beats != 0)
            $error("%0d predicted results never arrived", pending_beats);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
